FILE: rtl/lcm_pkg.sv
// Shared types and constants for the least-common-multiple block.
// Used by the top level and by the bit-serial divider and multiplier.
// No dependencies.
`default_nettype none

package lcm_pkg;

    // Fixed widths of the item fields on the top-level ports.
    localparam int SIZE_PORT_WIDTH = 32;
    localparam int RESULT_WIDTH    = 64;

    // Result given when both sizes are zero.
    localparam logic [RESULT_WIDTH-1:0] DEFAULT_SIZE = RESULT_WIDTH'(8 * 1024);

    // Status of one sequential arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

FILE: rtl/lcm_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Gives quotient and remainder once done is raised after start.
// Depends on lcm_pkg for the status struct.
`default_nettype none

module lcm_div #(
    parameter int W = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [W-1:0]        dividend,
    input  wire logic [W-1:0]        divisor,
    output logic [W-1:0]             quotient,
    output logic [W-1:0]             remainder,
    output lcm_pkg::unit_stat_t      stat
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [W:0]    trial;
    logic [W+1:0]  diff;
    logic          fits;

    // Shift the next dividend bit into the partial remainder and try to subtract.
    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};
    assign fits  = ~diff[W+1];

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

FILE: rtl/lcm_mul.sv
// Shift-add multiplier that retires one multiplier bit per cycle.
// Gives the 2W-bit product once done is raised after start.
// Depends on lcm_pkg for the status struct.
`default_nettype none

module lcm_mul #(
    parameter int W = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [W-1:0]        mcand,
    input  wire logic [W-1:0]        mplier,
    output logic [2*W-1:0]           product,
    output lcm_pkg::unit_stat_t      stat
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]  hi_reg, hi_next;
    logic [W-1:0]  lo_reg, lo_next;
    logic [W-1:0]  mcd_reg, mcd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [W:0]    sum;

    // The low half holds the unused multiplier bits and collects product bits from above.
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcd_reg} : '0);

    always_comb
    begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        mcd_next  = mcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            hi_next   = '0;
            lo_next   = mplier;
            mcd_next  = mcand;
            cnt_next  = CW'(W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[W:1];
            lo_next  = {sum[0], lo_reg[W-1:1]};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        mcd_reg <= mcd_next;
    end

    assign product   = {hi_reg, lo_reg};
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

FILE: rtl/lcm_of_two_sizes.sv
// Top level of the least-common-multiple block: sequencer around a shared
// bit-serial divider (lcm_div) and a bit-serial multiplier (lcm_mul).
// Depends on lcm_pkg.
//
// Usage: present size_a and size_b with start high; the item is taken at a
// rising edge where start is high and busy is low. Only the low SIZE_WIDTH
// bits of each size are used. busy stays high until the result is out.
// The result appears on common_multiple for exactly one cycle with done high;
// the receiver cannot stall it, so it must capture it in that cycle.
// Sequence: if either size is zero, the result is registered when the item is
// taken and no unit runs. Otherwise the block runs Euclid's loop of remainder
// steps plus one final division of size_a by the gcd, then one multiply by
// size_b, each in the one-bit-per-cycle divider or multiplier. One item is in
// flight at a time; the next may start the cycle after done. Reset returns
// the sequencer to idle and drops busy and done; no item survives it.
`default_nettype none

module lcm_of_two_sizes #(
    parameter int SIZE_WIDTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic [lcm_pkg::SIZE_PORT_WIDTH-1:0]    size_a,
    input  wire logic [lcm_pkg::SIZE_PORT_WIDTH-1:0]    size_b,
    output logic                                        done,
    output logic [lcm_pkg::RESULT_WIDTH-1:0]            common_multiple
);

    localparam int W  = SIZE_WIDTH;
    localparam int RW = lcm_pkg::RESULT_WIDTH;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MOD  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  n_reg, n_next;
    logic [RW-1:0] result_reg, result_next;

    logic [W-1:0]  in_a, in_b;
    logic          div_start, mul_start;
    logic [W-1:0]  div_dividend, div_divisor;
    logic [W-1:0]  div_quo, div_rem;
    logic [2*W-1:0] mul_prod;
    lcm_pkg::unit_stat_t div_stat, mul_stat;

    assign in_a = size_a[W-1:0];
    assign in_b = size_b[W-1:0];

    lcm_div #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    lcm_mul #(.W(W)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (b_reg),
        .mplier  (div_quo),
        .product (mul_prod),
        .stat    (mul_stat)
    );

    always_comb
    begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        n_next       = n_reg;
        result_next  = result_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        mul_start    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    a_next = in_a;
                    b_next = in_b;
                    n_next = in_b;
                    if (in_a == '0)
                    begin
                        result_next = (in_b == '0) ? lcm_pkg::DEFAULT_SIZE : RW'(in_b);
                        state_next  = ST_OUT;
                    end
                    else if (in_b == '0)
                    begin
                        result_next = RW'(in_a);
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = in_a;
                        div_divisor  = in_b;
                        state_next   = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                if (div_stat.done)
                begin
                    div_start = 1'b1;
                    if (div_rem == '0)
                    begin
                        // n_reg is the gcd; divide size_a by it.
                        div_dividend = a_reg;
                        div_divisor  = n_reg;
                        state_next   = ST_DIV;
                    end
                    else
                    begin
                        div_dividend = n_reg;
                        div_divisor  = div_rem;
                        n_next       = div_rem;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    result_next = RW'(mul_prod);
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        n_reg      <= n_next;
        result_reg <= result_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = (state_reg == ST_OUT);
    assign common_multiple = result_reg;

    // The sequencer never restarts a unit that is still working.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    // The two units never work at the same time.
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_stat.busy && mul_stat.busy))
        else $error("divider and multiplier both busy");

    // An accepted item keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // The result strobe lasts one cycle and then the block is free.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire
